// ----- design/mtrr_pkg.sv -----
// Shared types, codes and sizes for the member table with round-robin pick.
// Used by mtrr_seq and member_table_round_robin_pick; depends on nothing.
package mtrr_pkg;

  localparam int MAX_MEMBERS_DEF = 16;
  localparam int ID_SPACE        = 64;

  localparam int MODE_W   = 2;
  localparam int ID_W     = 6;
  localparam int MASK_W   = 64;
  localparam int STATUS_W = 2;
  localparam int OSLOT_W  = 4;
  localparam int OCOUNT_W = 5;

  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PICK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOCHG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd3;

  typedef struct packed {
    logic [OCOUNT_W-1:0] member_count;
    logic [OSLOT_W-1:0]  chosen_slot;
    logic [ID_W-1:0]     chosen_id;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

// ----- design/mtrr_mem.sv -----
// Member identifier store: one write port, one read port, registered read data.
// Standalone; uses only the widths given by its parameters.
module mtrr_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/mtrr_seq.sv -----
// Sequencer for add, delete and pick: walks the identifier store one read a cycle.
// Depends on mtrr_pkg; drives the ports of mtrr_mem.
module mtrr_seq #(
  parameter int MAX_MEMBERS = mtrr_pkg::MAX_MEMBERS_DEF,
  parameter int SW = $clog2(MAX_MEMBERS),
  parameter int CW = $clog2(MAX_MEMBERS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mtrr_pkg::MODE_W-1:0]  in_mode,
  input  logic [mtrr_pkg::ID_W-1:0]    in_id,
  input  logic [mtrr_pkg::MASK_W-1:0]  in_avail,
  output logic                         mem_we,
  output logic [SW-1:0]                mem_waddr,
  output logic [mtrr_pkg::ID_W-1:0]    mem_wdata,
  output logic [SW-1:0]                mem_raddr,
  input  logic [mtrr_pkg::ID_W-1:0]    mem_rdata,
  output logic                         res_valid,
  input  logic                         res_ready,
  output mtrr_pkg::res_t               res
);
  import mtrr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state;
  logic [CW-1:0]     cnt;
  logic [SW-1:0]     last_slot;
  logic [MODE_W-1:0] op_mode;
  logic [ID_W-1:0]   op_id;
  logic [MASK_W-1:0] op_avail;
  logic [SW-1:0]     rd_slot;
  logic [CW-1:0]     left;
  logic [CW-1:0]     sh_idx;
  logic              pend;
  logic [SW-1:0]     pend_slot;

  logic          hit;
  logic          scan_issue;
  logic          shift_issue;
  logic          scan_end;
  logic [SW-1:0] rd_slot_wrap;
  logic [SW-1:0] ls;
  logic [SW-1:0] start_slot;
  logic          id_out_of_range;

  function automatic res_t make_res(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id,
                                    logic [SW-1:0] slot, logic [CW-1:0] n);
    res_t r;
    r.status       = st;
    r.chosen_id    = id;
    r.chosen_slot  = OSLOT_W'(slot);
    r.member_count = OCOUNT_W'(n);
    return r;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  assign id_out_of_range = ({1'b0, in_id} >= (ID_W + 1)'(ID_SPACE));

  // A stale pointer falls back to slot 0; the scan starts one past it.
  assign ls         = (CW'(last_slot) >= cnt) ? '0 : last_slot;
  assign start_slot = ((CW'(ls) + CW'(1)) == cnt) ? '0 : ls + SW'(1);

  assign rd_slot_wrap = ((CW'(rd_slot) + CW'(1)) == cnt) ? '0 : rd_slot + SW'(1);

  assign hit = (op_mode == MODE_PICK) ? op_avail[mem_rdata] : (mem_rdata == op_id);

  assign scan_issue  = (state == S_SCAN) && (left != '0) && !(pend && hit);
  assign shift_issue = (state == S_SHIFT) && (sh_idx < cnt);
  assign scan_end    = (state == S_SCAN) && !pend && (left == '0);

  assign mem_raddr = (state == S_SHIFT) ? SW'(sh_idx) : rd_slot;

  // Reads in the shift run ahead of the writes, so an entry is never read and
  // written in the same cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = SW'(cnt);
    mem_wdata = op_id;
    if (scan_end && (op_mode == MODE_ADD) && (cnt < CW'(MAX_MEMBERS))) begin
      mem_we = 1'b1;
    end else if ((state == S_SHIFT) && pend) begin
      mem_we    = 1'b1;
      mem_waddr = pend_slot - SW'(1);
      mem_wdata = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      last_slot <= '0;
      pend      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (in_valid) begin
            op_mode  <= in_mode;
            op_id    <= in_id;
            op_avail <= in_avail;
            rd_slot  <= '0;
            left     <= cnt;
            if ((in_mode == MODE_ADD) || (in_mode == MODE_DEL)) begin
              if (id_out_of_range) begin
                res   <= make_res(ST_NOCHG, '0, '0, cnt);
                state <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else if (in_mode == MODE_PICK) begin
              if (cnt == '0) begin
                res   <= make_res(ST_NONE, '0, '0, cnt);
                state <= S_DONE;
              end else begin
                last_slot <= ls;
                rd_slot   <= start_slot;
                state     <= S_SCAN;
              end
            end else begin
              res   <= make_res(ST_NOCHG, '0, '0, cnt);
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          pend <= scan_issue;
          if (scan_issue) begin
            pend_slot <= rd_slot;
            rd_slot   <= rd_slot_wrap;
            left      <= left - CW'(1);
          end
          if (pend && hit) begin
            if (op_mode == MODE_DEL) begin
              if ((CW'(pend_slot) + CW'(1)) < cnt) begin
                sh_idx <= CW'(pend_slot) + CW'(1);
                state  <= S_SHIFT;
              end else begin
                cnt   <= cnt - CW'(1);
                res   <= make_res(ST_OK, '0, '0, cnt - CW'(1));
                state <= S_DONE;
              end
            end else if (op_mode == MODE_PICK) begin
              last_slot <= pend_slot;
              res       <= make_res(ST_OK, mem_rdata, pend_slot, cnt);
              state     <= S_DONE;
            end else begin
              res   <= make_res(ST_NOCHG, '0, '0, cnt);
              state <= S_DONE;
            end
          end else if (scan_end) begin
            state <= S_DONE;
            if (op_mode == MODE_ADD) begin
              if (cnt >= CW'(MAX_MEMBERS)) begin
                res <= make_res(ST_FULL, '0, '0, cnt);
              end else begin
                cnt <= cnt + CW'(1);
                res <= make_res(ST_OK, '0, '0, cnt + CW'(1));
              end
            end else if (op_mode == MODE_PICK) begin
              res <= make_res(ST_NONE, '0, '0, cnt);
            end else begin
              res <= make_res(ST_NOCHG, '0, '0, cnt);
            end
          end
        end
        S_SHIFT: begin
          pend <= shift_issue;
          if (shift_issue) begin
            pend_slot <= SW'(sh_idx);
            sh_idx    <= sh_idx + CW'(1);
          end
          if (!pend && !shift_issue) begin
            cnt   <= cnt - CW'(1);
            res   <= make_res(ST_OK, '0, '0, cnt - CW'(1));
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_MEMBERS))
    else $error("member count above table size");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (cnt != $past(cnt)) |-> ((cnt == $past(cnt) + CW'(1)) || (cnt + CW'(1) == $past(cnt))))
    else $error("member count moved by more than one");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == S_SCAN) || (state == S_SHIFT)))
    else $error("table write outside scan or shift");

  a_pend_state: assert property (@(posedge clk) disable iff (rst)
    pend |-> ((state == S_SCAN) || (state == S_SHIFT)))
    else $error("read data pending outside scan or shift");

  a_pick_ptr: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (op_mode == MODE_PICK) && (res.status == ST_OK))
      |-> (res.chosen_slot == OSLOT_W'(last_slot)))
    else $error("pick result and round-robin pointer disagree");
`endif

endmodule

// ----- design/member_table_round_robin_pick.sv -----
// Member table with round-robin pick: identifier store, sequencer, output register.
// Depends on mtrr_pkg, mtrr_mem and mtrr_seq.
//
// Usage: each input transaction on the s_ channel carries one operation in
// s_tuser (add, delete or pick) with an identifier and an availability mask
// in s_tdata. Each operation gives exactly one result transaction on the m_
// channel: status in m_tuser, and picked identifier, its slot and the member
// count after the operation in m_tdata.
// Flow: an operation walks the stored identifiers one read per cycle from
// the single-port-read memory. Add and delete scan the stored members; delete
// then shifts the later members down, one moved entry after another; pick
// scans at most the whole table, from one past the round-robin pointer.
// One operation is in flight at a time; s_tready is high when the sequencer
// is idle, also while an earlier result still waits in the output register.
// Reset empties the table and points the round-robin pointer at slot 0; the
// memory itself is not cleared, since only data from slots below the count is used.
// When the receiver stalls, the result holds in the output register and the
// next operation finishes but waits until the register frees.
module member_table_round_robin_pick #(
  parameter int MAX_MEMBERS = mtrr_pkg::MAX_MEMBERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // member_id[5:0], avail_mask[69:6], zero fill
  input  logic [1:0]  s_tuser,  // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // chosen_id[5:0], chosen_slot[9:6], member_count[14:10]
  output logic [1:0]  m_tuser   // status[1:0]
);
  import mtrr_pkg::*;

  localparam int SW = $clog2(MAX_MEMBERS);
  localparam int CW = $clog2(MAX_MEMBERS + 1);

  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [ID_W-1:0] mem_wdata;
  logic [SW-1:0] mem_raddr;
  logic [ID_W-1:0] mem_rdata;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  res_t          out_res;

  mtrr_mem #(
    .DEPTH (MAX_MEMBERS),
    .AW    (SW),
    .DW    (ID_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mtrr_seq #(
    .MAX_MEMBERS (MAX_MEMBERS),
    .SW          (SW),
    .CW          (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_id     (s_tdata[5:0]),
    .in_avail  (s_tdata[69:6]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.status;
  assign m_tdata = {1'b0, out_res.member_count, out_res.chosen_slot, out_res.chosen_id};

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for member_table_round_robin_pick: queued operations,
// a streaming driver and monitor, and an in-bench model of the member table.
// Depends on mtrr_pkg and the block's RTL only.
module tb_top;
  import mtrr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int TABLE_DEPTH = MAX_MEMBERS_DEF;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic [MASK_W-1:0] mask;
    logic              hold;  // wait until every pending result has come back
  } op_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // member_id[5:0], avail_mask[69:6], zero fill
  logic [1:0]  s_tuser = '0;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // chosen_id[5:0], chosen_slot[9:6], member_count[14:10]
  logic [1:0]  m_tuser;        // status[1:0]

  member_table_round_robin_pick DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  op_t  op_queue[$];
  res_t pending_results[$];
  op_t  cur_op = '0;
  int   ops_accepted = 0;
  int   results_seen = 0;
  int   error_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;

  // Model of the table as the block should hold it.
  logic [ID_W-1:0] tbl_ids [TABLE_DEPTH];
  int              tbl_count = 0;
  int              rr_slot = 0;

  // Membership seen by the stimulus generator, used to aim deletes and picks.
  logic [MASK_W-1:0] gen_set = '0;
  int                gen_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int slot_of(input logic [ID_W-1:0] id);
    int k;
    slot_of = -1;
    for (k = tbl_count - 1; k >= 0; k--) begin
      if (tbl_ids[k] == id) slot_of = k;
    end
  endfunction

  function automatic res_t apply_op(input op_t op);
    res_t r;
    int   pos;
    int   n;
    int   slot;
    bit   found;
    r = '0;
    r.status = ST_NOCHG;
    case (op.mode)
      MODE_ADD: begin
        if (slot_of(op.id) >= 0) begin
          r.status = ST_NOCHG;
        end else if (tbl_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_ids[tbl_count] = op.id;
          tbl_count++;
          r.status = ST_OK;
        end
      end
      MODE_DEL: begin
        pos = slot_of(op.id);
        if (pos >= 0) begin
          tbl_count--;
          for (n = pos; n < tbl_count; n++) tbl_ids[n] = tbl_ids[n + 1];
          r.status = ST_OK;
        end
      end
      MODE_PICK: begin
        r.status = ST_NONE;
        if (tbl_count != 0) begin
          // A pointer left beyond the table by deletes restarts at slot 0.
          if (rr_slot >= tbl_count) rr_slot = 0;
          found = 1'b0;
          for (n = 1; n <= tbl_count; n++) begin
            slot = (rr_slot + n) % tbl_count;
            if (!found && op.mask[tbl_ids[slot]]) begin
              found = 1'b1;
              rr_slot = slot;
              r.status = ST_OK;
              r.chosen_id = tbl_ids[slot];
              r.chosen_slot = slot[OSLOT_W-1:0];
            end
          end
        end
      end
      default: r.status = ST_NOCHG;
    endcase
    r.member_count = tbl_count[OCOUNT_W-1:0];
    return r;
  endfunction

  // Driver: presents queued operations and records the prediction for each
  // accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        pending_results.push_back(apply_op(cur_op));
        ops_accepted <= ops_accepted + 1;
      end
      if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          (!op_queue[0].hold || (!s_tvalid && ops_accepted == results_seen))) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, op_queue[0].mask, op_queue[0].id};
        s_tuser  <= op_queue[0].mode;
        cur_op   <= op_queue[0];
        void'(op_queue.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_seen >= ops_accepted || pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result tuser=%0d tdata=%h", m_tuser, m_tdata));
        end else begin
          if (m_tuser != pending_results[0].status)
            flag_error($sformatf("result %0d: status got %0d want %0d", results_seen,
                                 m_tuser, pending_results[0].status));
          if (m_tdata[5:0] != pending_results[0].chosen_id)
            flag_error($sformatf("result %0d: chosen_id got %0d want %0d", results_seen,
                                 m_tdata[5:0], pending_results[0].chosen_id));
          if (m_tdata[9:6] != pending_results[0].chosen_slot)
            flag_error($sformatf("result %0d: chosen_slot got %0d want %0d", results_seen,
                                 m_tdata[9:6], pending_results[0].chosen_slot));
          if (m_tdata[14:10] != pending_results[0].member_count)
            flag_error($sformatf("result %0d: member_count got %0d want %0d", results_seen,
                                 m_tdata[14:10], pending_results[0].member_count));
          void'(pending_results.pop_front());
        end
        results_seen <= results_seen + 1;
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic queue_op(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                          input logic [MASK_W-1:0] mask, input bit hold);
    op_t op;
    op.mode = mode;
    op.id   = id;
    op.mask = mask;
    op.hold = hold;
    op_queue.push_back(op);
    if (mode == MODE_ADD && !gen_set[id] && gen_count < TABLE_DEPTH) begin
      gen_set[id] = 1'b1;
      gen_count++;
    end else if (mode == MODE_DEL && gen_set[id]) begin
      gen_set[id] = 1'b0;
      gen_count--;
    end
  endtask

  function automatic logic [ID_W-1:0] any_member();
    logic [ID_W-1:0] id;
    id = ID_W'($urandom_range(63));
    while (!gen_set[id]) id = ID_W'($urandom_range(63));
    return id;
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_random(input int n_ops, input bit hold_first);
    int i;
    int roll;
    int add_pct;
    bit hold;
    logic [MASK_W-1:0] mask;
    for (i = 0; i < n_ops; i++) begin
      hold = (i == 0) ? hold_first : ($urandom_range(99) == 0);
      roll = $urandom_range(99);
      add_pct = (gen_count >= TABLE_DEPTH) ? 20 : 38;
      if (roll < 4) begin
        queue_op(MODE_UNUSED, ID_W'($urandom_range(63)), rand_mask(), hold);
      end else if (roll < 4 + add_pct) begin
        if (gen_count > 0 && $urandom_range(9) == 0)
          queue_op(MODE_ADD, any_member(), rand_mask(), hold);
        else
          queue_op(MODE_ADD, ID_W'($urandom_range(63)), rand_mask(), hold);
      end else if (roll < 4 + add_pct + 22) begin
        if (gen_count > 0 && $urandom_range(99) < 85)
          queue_op(MODE_DEL, any_member(), rand_mask(), hold);
        else
          queue_op(MODE_DEL, ID_W'($urandom_range(63)), rand_mask(), hold);
      end else if (roll < 4 + add_pct + 25 && gen_count > 0) begin
        // Empty the table in a burst so that low counts and the empty case recur.
        while (gen_count > 0) queue_op(MODE_DEL, any_member(), rand_mask(), hold);
      end else begin
        case ($urandom_range(5))
          0: mask = rand_mask();
          1: mask = gen_set & rand_mask() & rand_mask();
          2: mask = (gen_count > 0) ? (64'd1 << any_member()) : rand_mask();
          3: mask = '0;
          4: mask = '1;
          default: mask = ~gen_set;
        endcase
        queue_op(MODE_PICK, ID_W'($urandom_range(63)), mask, hold);
      end
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int n_ops);
    send_idle_pct = idle;
    stall_pct = stall;
    queue_random(n_ops, 1'b1);
    while (op_queue.size() != 0) @(posedge clk);
  endtask

  initial begin
    int k;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty table, unused mode, duplicates, full table,
    // wrap-around and a stale pointer after a delete.
    queue_op(MODE_PICK, 6'd0, '1, 1'b0);
    queue_op(MODE_UNUSED, 6'd63, '1, 1'b0);
    queue_op(MODE_DEL, 6'd5, '0, 1'b0);
    queue_op(MODE_ADD, 6'd63, '0, 1'b0);
    queue_op(MODE_ADD, 6'd63, '1, 1'b0);
    queue_op(MODE_ADD, 6'd0, '0, 1'b0);
    queue_op(MODE_PICK, 6'd0, '1, 1'b0);
    queue_op(MODE_PICK, 6'd0, '0, 1'b0);
    queue_op(MODE_PICK, 6'd0, 64'd1 << 63, 1'b0);
    for (k = 1; k <= 14; k++) queue_op(MODE_ADD, k[ID_W-1:0], rand_mask(), 1'b0);
    queue_op(MODE_ADD, 6'd40, '1, 1'b0);
    queue_op(MODE_PICK, 6'd0, 64'd1 << 14, 1'b0);
    queue_op(MODE_DEL, 6'd63, '0, 1'b0);
    queue_op(MODE_PICK, 6'd0, '1, 1'b0);
    // The member just picked is the only one available, so the scan wraps to it.
    queue_op(MODE_PICK, 6'd0, 64'd1 << 1, 1'b0);

    run_phase(0, 0, 190);
    run_phase(54, 0, 190);
    run_phase(0, 54, 190);
    run_phase(19, 19, 190);

    while (op_queue.size() != 0 || s_tvalid || ops_accepted != results_seen)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

endmodule

// ----- member_table_round_robin_pick.f -----
design/mtrr_pkg.sv
design/mtrr_mem.sv
design/mtrr_seq.sv
design/member_table_round_robin_pick.sv
tb/tb_top.sv
